FILE: src/load_history_address_resolver_assert.svh
// ---------------------------------------------------------------------------
// load_history_address_resolver assertion macros
// Concurrent checks on clk, disabled while rst_n is low; empty when SYNTH.
// ---------------------------------------------------------------------------
`ifndef LOAD_HISTORY_ADDRESS_RESOLVER_ASSERT_SVH
`define LOAD_HISTORY_ADDRESS_RESOLVER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define LHAR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lhar assertion failed");
// next-cycle implication
`define LHAR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lhar assertion failed");
`else
`define LHAR_ASSERT_NOW(label, ante, cons)
`define LHAR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: src/lhar_pkg.sv
// ---------------------------------------------------------------------------
// lhar_pkg
// Shared types and constants of the load history address resolver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lhar_pkg;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned QUEUE_D = 2;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic {
    REQ_RECORD  = 1'b0,
    REQ_RESOLVE = 1'b1
  } req_kind_t;

  // one command word between front and back
  typedef struct packed {
    req_kind_t kind;
    addr_t     addr_a;   // source base, or query address on a resolve
    addr_t     addr_b;   // destination base
    addr_t     len;      // copy length
  } cmd_t;

  typedef struct packed {
    addr_t src;
    addr_t dst;
    addr_t len;
  } rec_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

endpackage

`default_nettype wire

FILE: src/lhar_queue.sv
// ---------------------------------------------------------------------------
// lhar_queue
// Short command queue between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhar_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lhar_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output lhar_pkg::cmd_t     pop_data
);
  import lhar_pkg::*;

  localparam int unsigned PW = (QUEUE_D > 1) ? $clog2(QUEUE_D) : 1;
  localparam int unsigned CW = $clog2(QUEUE_D + 1);

  cmd_t          slot_r [QUEUE_D];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(QUEUE_D));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(QUEUE_D - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(QUEUE_D - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: src/lhar_front.sv
// ---------------------------------------------------------------------------
// lhar_front
// Input register: takes a word, sorts it into a record or resolve command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhar_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          in_req_type,
  input  wire lhar_pkg::addr_t in_source_base,
  input  wire lhar_pkg::addr_t in_dest_base,
  input  wire lhar_pkg::addr_t in_copy_length,
  input  wire lhar_pkg::addr_t in_query_addr,
  output logic               q_push,
  output lhar_pkg::cmd_t     q_data,
  input  wire logic          q_full
);
  import lhar_pkg::*;

  logic fe_valid_r, fe_valid_nxt;
  cmd_t fe_cmd_r, fe_cmd_nxt;
  logic take;

  assign in_stall = fe_valid_r && q_full;
  assign take     = in_valid && !in_stall;
  assign q_push   = fe_valid_r && !q_full;
  assign q_data   = fe_cmd_r;

  always_comb begin
    fe_valid_nxt = fe_valid_r;
    fe_cmd_nxt   = fe_cmd_r;
    if (!in_stall) begin
      fe_valid_nxt = in_valid;
    end
    if (take) begin
      if (in_req_type == REQ_RESOLVE) begin
        // only the query travels on a resolve
        fe_cmd_nxt.kind   = REQ_RESOLVE;
        fe_cmd_nxt.addr_a = in_query_addr;
        fe_cmd_nxt.addr_b = '0;
        fe_cmd_nxt.len    = '0;
      end else begin
        fe_cmd_nxt.kind   = REQ_RECORD;
        fe_cmd_nxt.addr_a = in_source_base;
        fe_cmd_nxt.addr_b = in_dest_base;
        fe_cmd_nxt.len    = in_copy_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_valid_r <= 1'b0;
    end else begin
      fe_valid_r <= fe_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fe_cmd_r <= fe_cmd_nxt;
  end

endmodule

`default_nettype wire

FILE: src/lhar_back.sv
// ---------------------------------------------------------------------------
// lhar_back
// Record ring memory and newest-first search sequencer with output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "load_history_address_resolver_assert.svh"

module lhar_back #(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire lhar_pkg::cmd_t  q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output lhar_pkg::addr_t      out_source_addr,
  output logic                 out_hit
);
  import lhar_pkg::*;

  localparam int unsigned IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(HISTORY_DEPTH);

  rec_t mem [HISTORY_DEPTH];
  rec_t rd_data_r;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [FILL_W-1:0] cnt_r, cnt_nxt;
  addr_t             query_r, query_nxt;
  logic              out_valid_r, out_valid_nxt;
  addr_t             out_source_r, out_source_nxt;
  logic              out_hit_r, out_hit_nxt;

  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              out_free;
  logic              match;
  addr_t             rng_end, resolved;
  logic              last_rec, scan_done, empty_miss;

  function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] idx);
    prev_idx = (idx == '0) ? LAST_IDX : idx - IDX_W'(1);
  endfunction

  assign out_free = !out_valid_r || !out_stall;

  // a wrapped range ends at or below its start, so it fails q < end
  assign rng_end  = rd_data_r.dst + rd_data_r.len;
  assign resolved = rd_data_r.src + (query_r - rd_data_r.dst);
  assign match    = (rd_data_r.len != '0) && (query_r >= rd_data_r.dst)
                    && (query_r < rng_end);
  assign last_rec = (cnt_r + FILL_W'(1)) == fill_r;
  assign scan_done  = (state_r == ST_SCAN) && (match || last_rec);
  assign empty_miss = (q_data.kind == REQ_RESOLVE) && (fill_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty && q_data.kind == REQ_RESOLVE && !empty_miss) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    slot_nxt       = slot_r;
    fill_nxt       = fill_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    query_nxt      = query_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_source_nxt = out_source_r;
    out_hit_nxt    = out_hit_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = ptr_r;
    q_pop          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_data.kind == REQ_RECORD) begin
            q_pop    = 1'b1;
            wr_en    = 1'b1;
            slot_nxt = (slot_r == LAST_IDX) ? '0 : slot_r + IDX_W'(1);
            if (fill_r != FULL_CNT) begin
              fill_nxt = fill_r + FILL_W'(1);
            end
          end else if (empty_miss) begin
            if (out_free) begin
              q_pop          = 1'b1;
              out_valid_nxt  = 1'b1;
              out_source_nxt = '0;
              out_hit_nxt    = 1'b0;
            end
          end else begin
            // start at the newest record
            q_pop     = 1'b1;
            rd_en     = 1'b1;
            rd_addr   = prev_idx(slot_r);
            ptr_nxt   = prev_idx(slot_r);
            cnt_nxt   = '0;
            query_nxt = q_data.addr_a;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          // hold the read data until the output register frees
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_source_nxt = match ? resolved : '0;
            out_hit_nxt    = match;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = prev_idx(ptr_r);
          ptr_nxt = prev_idx(ptr_r);
          cnt_nxt = cnt_r + FILL_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    cnt_r        <= cnt_nxt;
    query_r      <= query_nxt;
    out_source_r <= out_source_nxt;
    out_hit_r    <= out_hit_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_r] <= '{src: q_data.addr_a, dst: q_data.addr_b, len: q_data.len};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_source_addr = out_source_r;
  assign out_hit         = out_hit_r;

  `LHAR_ASSERT_NOW(a_scan_in_fill, state_r == ST_SCAN, cnt_r < fill_r)
  `LHAR_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= FULL_CNT)
  `LHAR_ASSERT_NOW(a_miss_zero, out_valid_r && !out_hit_r, out_source_r == '0)
  `LHAR_ASSERT_NOW(a_pop_idle, q_pop, state_r == ST_IDLE && !q_empty)
  `LHAR_ASSERT_NEXT(a_scan_start, state_r == ST_IDLE && rd_en, state_r == ST_SCAN)

endmodule

`default_nettype wire

FILE: src/load_history_address_resolver.sv
// Path: a record word passes the front register and the queue, then is written to the ring;
//   a resolve word passes the same two, then searches up to HISTORY_DEPTH records, newest first.
// Throughput: one record per cycle while the search sequencer is idle and the queue has room; a
//   resolve holds the sequencer while it reads records through the ring's single read port.
// Reset: synchronous active-low rst_n empties the ring and the queue; ring
//   contents are not cleared.
// ---------------------------------------------------------------------------
// load_history_address_resolver
// Ring of recent copy records; resolves a destination address to its source.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module load_history_address_resolver #(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            in_req_type,
  input  wire lhar_pkg::addr_t in_source_base,
  input  wire lhar_pkg::addr_t in_dest_base,
  input  wire lhar_pkg::addr_t in_copy_length,
  input  wire lhar_pkg::addr_t in_query_addr,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output lhar_pkg::addr_t      out_source_addr,
  output logic                 out_hit
);
  import lhar_pkg::*;

  logic push, full, pop, empty;
  cmd_t push_data, pop_data;

  lhar_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_source_base (in_source_base),
    .in_dest_base   (in_dest_base),
    .in_copy_length (in_copy_length),
    .in_query_addr  (in_query_addr),
    .q_push         (push),
    .q_data         (push_data),
    .q_full         (full)
  );

  lhar_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (pop_data)
  );

  lhar_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (empty),
    .q_data          (pop_data),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_source_addr (out_source_addr),
    .out_hit         (out_hit)
  );

endmodule

`default_nettype wire

FILE: bench/load_history_address_resolver_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// load_history_address_resolver checker
// Watches both channels of the resolver, keeps its own ring of copy records,
// predicts the answer of every accepted resolve word and compares it with
// the answers that leave the block, oldest first.
// ---------------------------------------------------------------------------
module resolve_checker #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_req_type,
  input  lhar_pkg::addr_t     in_source_base,
  input  lhar_pkg::addr_t     in_dest_base,
  input  lhar_pkg::addr_t     in_copy_length,
  input  lhar_pkg::addr_t     in_query_addr,
  input  logic                out_valid,
  input  logic                out_stall,
  input  lhar_pkg::addr_t     out_source_addr,
  input  logic                out_hit,
  output int unsigned         fail_count,
  output int unsigned         pending
);
  import lhar_pkg::*;

  typedef struct {
    addr_t src;
    logic  hit;
  } answer_t;

  addr_t       hist_src [DEPTH];
  addr_t       hist_dst [DEPTH];
  addr_t       hist_len [DEPTH];
  int unsigned hist_slot;
  int unsigned hist_fill;
  answer_t     expected_answers [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    hist_slot  = 0;
    hist_fill  = 0;
  end

  // newest record first; zero-length and wrapping ranges never match
  function automatic answer_t predict_source(addr_t q);
    answer_t     a;
    int unsigned idx;
    addr_t       stop;
    a.src = '0;
    a.hit = 1'b0;
    for (int unsigned i = 0; i < hist_fill; i++) begin
      idx = (hist_slot + DEPTH - 1 - i) % DEPTH;
      if (hist_len[idx] == '0) continue;
      stop = hist_dst[idx] + hist_len[idx];
      if (q >= hist_dst[idx] && q < stop) begin
        a.src = hist_src[idx] + (q - hist_dst[idx]);
        a.hit = 1'b1;
        return a;
      end
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      hist_slot = 0;
      hist_fill = 0;
      expected_answers.delete();
    end else begin
      // compare first: an answer leaving now belongs to an older word
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: answer with none expected: got src %h hit %b",
                   $realtime, out_source_addr, out_hit);
          fail_count++;
        end else begin
          want = expected_answers.pop_front();
          if (out_source_addr !== want.src) begin
            $display("%0t: source_addr mismatch: expected %h actual %h",
                     $realtime, want.src, out_source_addr);
            fail_count++;
          end
          if (out_hit !== want.hit) begin
            $display("%0t: hit mismatch: expected %b actual %b",
                     $realtime, want.hit, out_hit);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (req_kind_t'(in_req_type) == REQ_RECORD) begin
          hist_src[hist_slot] = in_source_base;
          hist_dst[hist_slot] = in_dest_base;
          hist_len[hist_slot] = in_copy_length;
          hist_slot = (hist_slot + 1) % DEPTH;
          if (hist_fill < DEPTH) hist_fill++;
        end else begin
          expected_answers.push_back(predict_source(in_query_addr));
        end
      end
    end
    pending = expected_answers.size();
  end

endmodule

FILE: bench/load_history_address_resolver_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// load_history_address_resolver testbench
// Directed words for the edge cases of the ring search, then random record
// and resolve traffic mostly aimed at the live records, with random idling on both
// channels; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module load_history_address_resolver_tb;
  import lhar_pkg::*;

  localparam int unsigned DEPTH      = 8;
  localparam int unsigned RAND_WORDS = 450;
  localparam int unsigned CALM_WORDS = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b0;
  addr_t       in_source_base = '0;
  addr_t       in_dest_base = '0;
  addr_t       in_copy_length = '0;
  addr_t       in_query_addr = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  addr_t       out_source_addr;
  logic        out_hit;
  int unsigned fail_count;
  int unsigned pending;
  logic        quiet = 1'b0;

  // destinations and lengths of recent records, to aim queries at
  addr_t       trk_dst [DEPTH];
  addr_t       trk_len [DEPTH];
  int unsigned trk_n = 0;
  int unsigned trk_ptr = 0;

  always #10 clk = ~clk;

  load_history_address_resolver #(
    .HISTORY_DEPTH(DEPTH)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_source_base (in_source_base),
    .in_dest_base   (in_dest_base),
    .in_copy_length (in_copy_length),
    .in_query_addr  (in_query_addr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_source_addr(out_source_addr),
    .out_hit        (out_hit)
  );

  resolve_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_source_base (in_source_base),
    .in_dest_base   (in_dest_base),
    .in_copy_length (in_copy_length),
    .in_query_addr  (in_query_addr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_source_addr(out_source_addr),
    .out_hit        (out_hit),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // hold the word until it is taken
  task automatic send_word(input req_kind_t kind, input addr_t s, input addr_t d,
                           input addr_t l, input addr_t q);
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_source_base <= s;
    in_dest_base   <= d;
    in_copy_length <= l;
    in_query_addr  <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_record(input addr_t s, input addr_t d, input addr_t l);
    send_word(REQ_RECORD, s, d, l, addr_t'($urandom));
    trk_dst[trk_ptr] = d;
    trk_len[trk_ptr] = l;
    trk_ptr = (trk_ptr + 1) % DEPTH;
    if (trk_n < DEPTH) trk_n++;
  endtask

  task automatic send_resolve(input addr_t q);
    send_word(REQ_RESOLVE, addr_t'($urandom), addr_t'($urandom), addr_t'($urandom), q);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic random_word();
    addr_t       s, d, l, q;
    int unsigned k;
    if ($urandom_range(0, 99) < 45) begin
      s = addr_t'($urandom);
      case ($urandom_range(0, 9))
        0:       l = '0;
        1:       l = addr_t'($urandom);
        2:       l = 16'hFFFF;
        default: l = addr_t'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 3))
        0:       d = addr_t'($urandom);
        1:       d = 16'hFFFF - addr_t'($urandom_range(0, 80));
        default: d = 16'h4000 + addr_t'($urandom_range(0, 255));
      endcase
      send_record(s, d, l);
    end else begin
      if (trk_n != 0 && $urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, trk_n - 1);
        case ($urandom_range(0, 5))
          0:       q = trk_dst[k];
          1:       q = trk_dst[k] + trk_len[k];
          2:       q = trk_dst[k] + trk_len[k] - 1;
          3:       q = trk_dst[k] - 1;
          default: q = trk_dst[k] + addr_t'($urandom_range(0, 63));
        endcase
      end else begin
        q = addr_t'($urandom);
      end
      send_resolve(q);
    end
  endtask

  // receiver stalls in bursts, none once the run goes quiet
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && rst_n && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty history
    send_resolve(16'h0000);
    send_resolve(16'hFFFF);
    sender_gap();
    // at both ends of one record and just outside it
    send_record(16'h1000, 16'h2000, 16'h0010);
    send_resolve(16'h2000);
    send_resolve(16'h200F);
    sender_gap();
    send_resolve(16'h2010);
    send_resolve(16'h1FFF);
    // zero length is skipped, the older record answers
    send_record(16'hAAAA, 16'h2000, 16'h0000);
    send_resolve(16'h2005);
    sender_gap();
    // overlap: newest wins
    send_record(16'h5000, 16'h2008, 16'h0010);
    send_resolve(16'h2008);
    send_resolve(16'h2004);
    // wrapping ranges never match; range ending at 0xFFFF does, source wraps
    send_record(16'h3000, 16'hFFF0, 16'h0010);
    send_resolve(16'hFFF5);
    send_record(16'hFFFA, 16'hFFF0, 16'h000F);
    send_resolve(16'hFFFE);
    sender_gap();
    // extreme fields
    send_record(16'hFFFF, 16'h0000, 16'hFFFF);
    send_resolve(16'h0000);
    send_resolve(16'hFFFE);
    // fill and overrun the ring
    for (int i = 0; i < DEPTH; i++) begin
      send_record(16'h6000 + 16'(i * 16'h0100), 16'h8000 + 16'(i * 16'h0100), 16'h0040);
    end
    send_resolve(16'h2000);
    send_resolve(16'h8000);
    send_record(16'h7777, 16'hC000, 16'h0040);
    send_resolve(16'h8000);

    // let everything drain before random traffic
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int unsigned n = 0; n < RAND_WORDS; n++) begin
      if (n == RAND_WORDS - CALM_WORDS) quiet = 1'b1;
      random_word();
      sender_gap();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
